// File: design/pooled_linked_list_manager_core_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros for the pooled linked list manager
// Shorthand for clocked implication checks with asynchronous reset disable.
// -----------------------------------------------------------------------------
`ifndef POOLED_LINKED_LIST_MANAGER_CORE_MACROS_SVH
`define POOLED_LINKED_LIST_MANAGER_CORE_MACROS_SVH

// Same-cycle implication.
`define PLLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PLLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pllm_pkg.sv
// -----------------------------------------------------------------------------
// pllm_pkg
// Shared types, codes and constants of the pooled linked list manager.
// -----------------------------------------------------------------------------
package pllm_pkg;

  localparam int unsigned PoolSizeDef = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned CountW      = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SPLIT  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]               func;
    logic                     list_sel;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] moved_count;
  } out_item_t;

  // Request to the shared node compare unit.
  typedef struct packed {
    logic              even_mode;
    logic [ValueW-1:0] node_value;
    logic [ValueW-1:0] key;
  } cmp_req_t;

endpackage

// File: design/pllm_ram.sv
// -----------------------------------------------------------------------------
// pllm_ram
// Generic single-write, single-read RAM with a registered read port.
// -----------------------------------------------------------------------------
module pllm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/pllm_match.sv
// -----------------------------------------------------------------------------
// pllm_match
// Shared node compare unit: value match for delete, even test for split.
// -----------------------------------------------------------------------------
module pllm_match import pllm_pkg::*; (
  input  cmp_req_t req_i,
  output logic     hit_o
);

  always_comb begin
    if (req_i.even_mode) begin
      hit_o = ~req_i.node_value[0];
    end else begin
      hit_o = (req_i.node_value == req_i.key);
    end
  end

endmodule

// File: design/pooled_linked_list_manager_core.sv
// Sequencing: an insert with a free node passes through S_INS to S_DONE; delete walks
// the list in S_DWALK up to the match, then S_DFIX when the match is not at the head;
// split walks the primary list in S_SWALK, adding S_SFIX per even node after a kept odd node.
// Throughput: one item at a time; the next item can be accepted in the cycle in which the
// result turns valid, and a stalled result holds the following item in its final state.
// Reset: lists empty, free list holds every node, ready at once; no clearing pass.
`include "pooled_linked_list_manager_core_macros.svh"
// -----------------------------------------------------------------------------
// pooled_linked_list_manager_core
// Node pool with a free list and two linked lists, driven by a small sequencer.
// -----------------------------------------------------------------------------
module pooled_linked_list_manager_core import pllm_pkg::*; #(
  parameter int unsigned PoolSize = PoolSizeDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(PoolSize);
  localparam int unsigned IW = $clog2(PoolSize + 1);
  localparam logic [IW-1:0] Nil = IW'(PoolSize);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_DWALK = 3'd2;
  localparam logic [2:0] S_DFIX  = 3'd3;
  localparam logic [2:0] S_SWALK = 3'd4;
  localparam logic [2:0] S_SFIX  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]    state_q, state_d;
  in_item_t      op_q, op_d;
  logic [IW-1:0] free_head_q, free_head_d;
  logic [IW-1:0] pri_head_q, pri_head_d;
  logic [IW-1:0] sec_head_q, sec_head_d;
  logic [IW-1:0] fill_q, fill_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] prev_q, prev_d;
  logic [IW-1:0] nxt_q, nxt_d;
  logic [IW-1:0] moved_q, moved_d;
  out_item_t     res_q, res_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_item_q, out_item_d;

  logic              nv_we, nn_we;
  logic [AW-1:0]     nv_waddr, nn_waddr, rd_addr;
  logic [ValueW-1:0] nv_wdata, val_rdata;
  logic [IW-1:0]     nn_wdata, next_rdata;

  cmp_req_t      cmp_req;
  logic          hit;
  logic          accept, out_free;
  logic [IW-1:0] ins_next, head_sel, moved_inc;

  pllm_ram #(.Width(ValueW), .Depth(PoolSize)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (nv_we),
    .waddr_i (nv_waddr),
    .wdata_i (nv_wdata),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  pllm_ram #(.Width(IW), .Depth(PoolSize)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (nn_we),
    .waddr_i (nn_waddr),
    .wdata_i (nn_wdata),
    .raddr_i (rd_addr),
    .rdata_o (next_rdata)
  );

  assign cmp_req.even_mode  = (state_q == S_SWALK);
  assign cmp_req.node_value = val_rdata;
  assign cmp_req.key        = op_q.value;

  pllm_match u_match (
    .req_i (cmp_req),
    .hit_o (hit)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Nodes below the fill mark were never handed out; their free link is the next lower node.
  always_comb begin
    if (free_head_q < fill_q) begin
      ins_next = (free_head_q == '0) ? Nil : free_head_q - IW'(1);
    end else begin
      ins_next = next_rdata;
    end
  end

  assign head_sel  = in_item_i.list_sel ? sec_head_q : pri_head_q;
  assign moved_inc = hit ? moved_q + IW'(1) : moved_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    free_head_d = free_head_q;
    pri_head_d  = pri_head_q;
    sec_head_d  = sec_head_q;
    fill_d      = fill_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    nxt_d       = nxt_q;
    moved_d     = moved_q;
    res_d       = res_q;
    nv_we       = 1'b0;
    nv_waddr    = AW'(free_head_q);
    nv_wdata    = op_q.value;
    nn_we       = 1'b0;
    nn_waddr    = AW'(cur_q);
    nn_wdata    = free_head_q;
    rd_addr     = AW'(cur_q);

    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d              = in_item_i;
          res_d.status      = ST_OK;
          res_d.slot        = '0;
          res_d.moved_count = '0;
          unique case (func_e'(in_item_i.func))
            FUNC_INSERT: begin
              if (free_head_q == Nil) begin
                res_d.status = ST_FULL;
                state_d      = S_DONE;
              end else begin
                rd_addr = AW'(free_head_q);
                state_d = S_INS;
              end
            end
            FUNC_DELETE: begin
              cur_d  = head_sel;
              prev_d = Nil;
              if (head_sel == Nil) begin
                res_d.status = ST_NOT_FOUND;
                state_d      = S_DONE;
              end else begin
                rd_addr = AW'(head_sel);
                state_d = S_DWALK;
              end
            end
            FUNC_SPLIT: begin
              sec_head_d = Nil;
              moved_d    = '0;
              cur_d      = pri_head_q;
              prev_d     = Nil;
              if (pri_head_q == Nil) begin
                state_d = S_DONE;
              end else begin
                rd_addr = AW'(pri_head_q);
                state_d = S_SWALK;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_INS: begin
        nv_we       = 1'b1;
        nv_waddr    = AW'(free_head_q);
        nv_wdata    = op_q.value;
        nn_we       = 1'b1;
        nn_waddr    = AW'(free_head_q);
        nn_wdata    = pri_head_q;
        free_head_d = ins_next;
        pri_head_d  = free_head_q;
        if (free_head_q < fill_q) begin
          fill_d = free_head_q;
        end
        res_d.slot = SlotW'(free_head_q);
        state_d    = S_DONE;
      end

      S_DWALK: begin
        if (hit) begin
          // Return the node to the free list now; relink its predecessor next cycle.
          nn_we       = 1'b1;
          nn_waddr    = AW'(cur_q);
          nn_wdata    = free_head_q;
          free_head_d = cur_q;
          res_d.slot  = SlotW'(cur_q);
          nxt_d       = next_rdata;
          if (prev_q == Nil) begin
            if (op_q.list_sel) begin
              sec_head_d = next_rdata;
            end else begin
              pri_head_d = next_rdata;
            end
            state_d = S_DONE;
          end else begin
            state_d = S_DFIX;
          end
        end else begin
          prev_d = cur_q;
          cur_d  = next_rdata;
          if (next_rdata == Nil) begin
            res_d.status = ST_NOT_FOUND;
            state_d      = S_DONE;
          end else begin
            rd_addr = AW'(next_rdata);
          end
        end
      end

      S_DFIX: begin
        nn_we    = 1'b1;
        nn_waddr = AW'(prev_q);
        nn_wdata = nxt_q;
        state_d  = S_DONE;
      end

      S_SWALK: begin
        moved_d = moved_inc;
        if (hit && (prev_q != Nil)) begin
          nn_we      = 1'b1;
          nn_waddr   = AW'(cur_q);
          nn_wdata   = sec_head_q;
          sec_head_d = cur_q;
          nxt_d      = next_rdata;
          state_d    = S_SFIX;
        end else begin
          if (hit) begin
            nn_we      = 1'b1;
            nn_waddr   = AW'(cur_q);
            nn_wdata   = sec_head_q;
            sec_head_d = cur_q;
            pri_head_d = next_rdata;
          end else begin
            prev_d = cur_q;
          end
          cur_d = next_rdata;
          if (next_rdata == Nil) begin
            res_d.moved_count = CountW'(moved_inc);
            state_d           = S_DONE;
          end else begin
            rd_addr = AW'(next_rdata);
          end
        end
      end

      S_SFIX: begin
        nn_we    = 1'b1;
        nn_waddr = AW'(prev_q);
        nn_wdata = nxt_q;
        cur_d    = nxt_q;
        if (nxt_q == Nil) begin
          res_d.moved_count = CountW'(moved_q);
          state_d           = S_DONE;
        end else begin
          rd_addr = AW'(nxt_q);
          state_d = S_SWALK;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= IW'(PoolSize - 1);
      pri_head_q  <= Nil;
      sec_head_q  <= Nil;
      fill_q      <= Nil;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      pri_head_q  <= pri_head_d;
      sec_head_q  <= sec_head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    nxt_q      <= nxt_d;
    moved_q    <= moved_d;
    res_q      <= res_d;
    out_item_q <= out_item_d;
  end

  `PLLM_ASSERT_NEXT(a_busy_after_accept, accept, state_q != S_IDLE, "idle right after accept")
  `PLLM_ASSERT_NOW(a_fresh_head, free_head_q < fill_q, free_head_q == fill_q - IW'(1),
    "free head below fill mark is not the next fresh node")
  `PLLM_ASSERT_NEXT(a_result_posted, (state_q == S_DONE) && out_free,
    out_valid_o && (state_q == S_IDLE), "finished item was not posted")

endmodule
